// ----- sv/grid_maze_path_search_defines.svh -----
// Assertion macros shared by the maze search RTL.
`ifndef GRID_MAZE_PATH_SEARCH_DEFINES_SVH
`define GRID_MAZE_PATH_SEARCH_DEFINES_SVH

// Check that a condition holds on every clock edge outside reset.
`define GMPS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition on one edge is followed by another on the next edge.
`define GMPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/gmps_pkg.sv -----
// Shared types and codes for the maze path search block.
package gmps_pkg;

  // Cell codes
  localparam logic [1:0] KIND_OPEN  = 2'd0;
  localparam logic [1:0] KIND_WALL  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_GOAL  = 2'd3;

  // Neighbor directions, in search order; DIR_DONE means all tried
  localparam int unsigned DIR_W = 3;
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd0;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  // Stream field widths
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned OUT_POS_W = 3;
  localparam int unsigned TDATA_W   = 8;

  typedef enum logic [3:0] {
    ST_CLR,    // clear the path marks, one per cycle
    ST_LOAD,   // take cells
    ST_DIV,    // split start position into row and column
    ST_STEP,   // try next direction of the top cell, or backtrack
    ST_CHK,    // judge the neighbor read from the grid
    ST_POP,    // restore the cell below the top
    ST_ORD,    // fetch the next path cell
    ST_OWR,    // hand a path cell to the output register
    ST_NF      // hand over the not-found result
  } state_t;

endpackage

// ----- sv/grid_maze_path_search.sv -----
// Top level of the depth-first maze path search block.
//
// Usage: cells stream in on the s_ side, one transaction per cell in
// row-major order; s_tdata[1:0] is the cell code (open, wall, start, goal)
// and s_tlast marks the final cell. Cells load at one per cycle. The
// transaction carrying s_tlast starts the search and drops s_tready until
// the last result has been placed in the output register and the path
// marks have been cleared, one mark per cycle.
// Search: the start position is split into row and column by repeated
// subtraction, then each direction tried takes a neighbor address, a grid
// and mark memory read and a check, and each backtrack a stack memory read.
// Results leave on the m_ side: the start cell, each path cell, then the
// goal with m_tlast set; m_tuser is the found flag. A failed search gives
// one result with m_tuser low. A stalled receiver holds the output register
// and pauses the sequencer. Reset empties the search state, sets both
// dimensions to 8 and runs the mark clearing pass before s_tready rises;
// the grid memory is not cleared. Configuration writes (cfg_index 0 rows,
// 1 columns) are always accepted and belong between grids.
`include "grid_maze_path_search_defines.svh"

module grid_maze_path_search #(
  parameter int unsigned MAX_ROWS = 8,
  parameter int unsigned MAX_COLS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // Cell stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [gmps_pkg::TDATA_W-1:0]    s_tdata,   // [1:0] cell_kind
  input  logic                            s_tlast,   // last_cell
  // Result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [gmps_pkg::TDATA_W-1:0]    m_tdata,   // [2:0] cell_row, [5:3] cell_col
  output logic                            m_tuser,   // found
  output logic                            m_tlast,   // path_end
  // Configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gmps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gmps_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CELLS = MAX_ROWS * MAX_COLS;
  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned CW    = $clog2(MAX_COLS);
  localparam int unsigned RCW   = $clog2(MAX_ROWS+1);
  localparam int unsigned CCW   = $clog2(MAX_COLS+1);
  localparam int unsigned PW    = $clog2(CELLS);
  localparam int unsigned DW    = $clog2(CELLS+1);
  localparam int unsigned SW    = RW + CW + gmps_pkg::DIR_W;
  localparam int unsigned OW    = gmps_pkg::OUT_POS_W;

  // Configuration registers
  logic [gmps_pkg::CFG_DATA_W-1:0] rows_cfg, cols_cfg;
  logic [RCW-1:0]                  rows_use;
  logic [CCW-1:0]                  cols_use;

  // Sequencer state
  gmps_pkg::state_t           state, state_next;
  logic [DW-1:0]              load_pos, load_pos_next;
  logic [PW-1:0]              start_pos, start_pos_next;
  logic                       start_seen, start_seen_next;
  logic [PW-1:0]              clr_idx, clr_idx_next;
  logic [PW-1:0]              div_rem, div_rem_next;
  logic [RCW-1:0]             div_row, div_row_next;
  logic [RW-1:0]              top_row, top_row_next;
  logic [CW-1:0]              top_col, top_col_next;
  logic [gmps_pkg::DIR_W-1:0] top_dir, top_dir_next;
  logic [DW-1:0]              depth, depth_next;
  logic                       nb_ok, nb_ok_next;
  logic [RW-1:0]              nb_row, nb_row_next;
  logic [CW-1:0]              nb_col, nb_col_next;
  logic [PW-1:0]              nb_pos, nb_pos_next;
  logic [RW-1:0]              goal_row, goal_row_next;
  logic [CW-1:0]              goal_col, goal_col_next;
  logic [DW-1:0]              out_idx, out_idx_next;

  // Output register
  logic           out_valid;
  logic           out_found, out_end;
  logic [OW-1:0]  out_row, out_col;
  logic           out_free, out_load;
  logic           load_found, load_end;
  logic [RW-1:0]  load_row;
  logic [CW-1:0]  load_col;

  // Memories and neighbor unit
  logic                       grid_we, grid_re;
  logic [PW-1:0]              grid_waddr;
  logic [gmps_pkg::KIND_W-1:0] grid_rd;
  logic                       mark_we, mark_wdata, mark_rd;
  logic [PW-1:0]              mark_waddr;
  logic                       stk_we, stk_re;
  logic [PW-1:0]              stk_waddr, stk_raddr;
  logic [SW-1:0]              stk_wdata, stk_rd;
  logic                       nbr_ok;
  logic [RW-1:0]              nbr_row;
  logic [CW-1:0]              nbr_col;
  logic [PW-1:0]              nbr_pos;

  logic [gmps_pkg::KIND_W-1:0] in_kind;
  logic                        in_fire;
  logic [DW-1:0]               depth_m1;

  assign in_kind  = s_tdata[gmps_pkg::KIND_W-1:0];
  assign in_fire  = s_tvalid && s_tready;
  assign depth_m1 = depth - DW'(1);
  assign out_free = !out_valid || m_tready;

  // Register writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= gmps_pkg::CFG_DATA_W'(8);
      cols_cfg <= gmps_pkg::CFG_DATA_W'(8);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gmps_pkg::CFG_ROWS: rows_cfg <= cfg_data;
        gmps_pkg::CFG_COLS: cols_cfg <= cfg_data;
        default:            rows_cfg <= rows_cfg;
      endcase
    end
  end

  // Clamp dimensions: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (rows_cfg == '0) begin
      rows_use = RCW'(1);
    end else if (rows_cfg > MAX_ROWS) begin
      rows_use = RCW'(MAX_ROWS);
    end else begin
      rows_use = RCW'(rows_cfg);
    end
    if (cols_cfg == '0) begin
      cols_use = CCW'(1);
    end else if (cols_cfg > MAX_COLS) begin
      cols_use = CCW'(MAX_COLS);
    end else begin
      cols_use = CCW'(cols_cfg);
    end
  end

  gmps_ram #(
    .WIDTH (gmps_pkg::KIND_W),
    .DEPTH (CELLS)
  ) u_grid_ram (
    .clk   (clk),
    .we    (grid_we),
    .waddr (grid_waddr),
    .wdata (in_kind),
    .re    (grid_re),
    .raddr (nbr_pos),
    .rdata (grid_rd)
  );

  // Path marks: read beside the grid memory, cleared by a pass after each run
  gmps_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .re    (grid_re),
    .raddr (nbr_pos),
    .rdata (mark_rd)
  );

  // Stack holds every cell below the top: row, column, next direction
  gmps_ram #(
    .WIDTH (SW),
    .DEPTH (CELLS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rd)
  );

  gmps_nbr #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_nbr (
    .row       (top_row),
    .col       (top_col),
    .dir       (top_dir),
    .rows_use  (rows_use),
    .cols_use  (cols_use),
    .in_bounds (nbr_ok),
    .nrow      (nbr_row),
    .ncol      (nbr_col),
    .npos      (nbr_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gmps_pkg::ST_CLR;
      load_pos   <= '0;
      start_pos  <= '0;
      start_seen <= 1'b0;
      depth      <= '0;
      clr_idx    <= '0;
    end else begin
      state      <= state_next;
      load_pos   <= load_pos_next;
      start_pos  <= start_pos_next;
      start_seen <= start_seen_next;
      depth      <= depth_next;
      clr_idx    <= clr_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    div_rem  <= div_rem_next;
    div_row  <= div_row_next;
    top_row  <= top_row_next;
    top_col  <= top_col_next;
    top_dir  <= top_dir_next;
    nb_ok    <= nb_ok_next;
    nb_row   <= nb_row_next;
    nb_col   <= nb_col_next;
    nb_pos   <= nb_pos_next;
    goal_row <= goal_row_next;
    goal_col <= goal_col_next;
    out_idx  <= out_idx_next;
  end

  always_comb begin
    state_next      = state;
    load_pos_next   = load_pos;
    start_pos_next  = start_pos;
    start_seen_next = start_seen;
    clr_idx_next    = clr_idx;
    div_rem_next    = div_rem;
    div_row_next    = div_row;
    top_row_next    = top_row;
    top_col_next    = top_col;
    top_dir_next    = top_dir;
    depth_next      = depth;
    nb_ok_next      = nb_ok;
    nb_row_next     = nb_row;
    nb_col_next     = nb_col;
    nb_pos_next     = nb_pos;
    goal_row_next   = goal_row;
    goal_col_next   = goal_col;
    out_idx_next    = out_idx;
    s_tready        = 1'b0;
    grid_we         = 1'b0;
    grid_waddr      = load_pos[PW-1:0];
    grid_re         = 1'b0;
    mark_we         = 1'b0;
    mark_waddr      = nb_pos;
    mark_wdata      = 1'b1;
    stk_we          = 1'b0;
    stk_waddr       = depth_m1[PW-1:0];
    stk_wdata       = {top_row, top_col, top_dir};
    stk_re          = 1'b0;
    stk_raddr       = out_idx[PW-1:0];
    out_load        = 1'b0;
    load_found      = 1'b1;
    load_end        = 1'b0;
    load_row        = top_row;
    load_col        = top_col;

    unique case (state)
      gmps_pkg::ST_CLR: begin
        // Drop one path mark per cycle over the whole store
        mark_we      = 1'b1;
        mark_waddr   = clr_idx;
        mark_wdata   = 1'b0;
        clr_idx_next = clr_idx + PW'(1);
        if (clr_idx == PW'(CELLS - 1)) begin
          clr_idx_next = '0;
          state_next   = gmps_pkg::ST_LOAD;
        end
      end

      gmps_pkg::ST_LOAD: begin
        s_tready = 1'b1;
        if (in_fire) begin
          // Cells beyond the grid capacity are dropped
          if (load_pos < CELLS) begin
            grid_we       = 1'b1;
            load_pos_next = load_pos + DW'(1);
            if (in_kind == gmps_pkg::KIND_START) begin
              start_pos_next  = load_pos[PW-1:0];
              start_seen_next = 1'b1;
            end
          end
          if (s_tlast) begin
            div_rem_next = start_pos_next;
            div_row_next = '0;
            state_next   = gmps_pkg::ST_DIV;
          end
        end
      end

      gmps_pkg::ST_DIV: begin
        // Subtract one row per cycle; running out of rows means no start
        if (!start_seen || div_row == rows_use) begin
          state_next = gmps_pkg::ST_NF;
        end else if (div_rem >= PW'(cols_use)) begin
          div_rem_next = div_rem - PW'(cols_use);
          div_row_next = div_row + RCW'(1);
        end else begin
          top_row_next = RW'(div_row);
          top_col_next = CW'(div_rem);
          top_dir_next = gmps_pkg::DIR_UP;
          depth_next   = DW'(1);
          mark_we      = 1'b1;
          mark_waddr   = start_pos;
          state_next   = gmps_pkg::ST_STEP;
        end
      end

      gmps_pkg::ST_STEP: begin
        if (top_dir >= gmps_pkg::DIR_DONE) begin
          // Backtrack; marks stay set for the rest of the run
          depth_next = depth_m1;
          if (depth == DW'(1)) begin
            state_next = gmps_pkg::ST_NF;
          end else begin
            stk_re     = 1'b1;
            stk_raddr  = PW'(depth - DW'(2));
            state_next = gmps_pkg::ST_POP;
          end
        end else begin
          grid_re      = 1'b1;
          nb_ok_next   = nbr_ok;
          nb_row_next  = nbr_row;
          nb_col_next  = nbr_col;
          nb_pos_next  = nbr_pos;
          top_dir_next = top_dir + gmps_pkg::DIR_W'(1);
          state_next   = gmps_pkg::ST_CHK;
        end
      end

      gmps_pkg::ST_CHK: begin
        state_next = gmps_pkg::ST_STEP;
        if (nb_ok) begin
          if (grid_rd == gmps_pkg::KIND_GOAL) begin
            goal_row_next = nb_row;
            goal_col_next = nb_col;
            out_idx_next  = '0;
            state_next    = gmps_pkg::ST_ORD;
          end else if (grid_rd != gmps_pkg::KIND_WALL && !mark_rd &&
                       depth < CELLS) begin
            // Push: park the current top in the stack memory
            stk_we       = 1'b1;
            mark_we      = 1'b1;
            top_row_next = nb_row;
            top_col_next = nb_col;
            top_dir_next = gmps_pkg::DIR_UP;
            depth_next   = depth + DW'(1);
          end
        end
      end

      gmps_pkg::ST_POP: begin
        top_row_next = stk_rd[SW-1 -: RW];
        top_col_next = stk_rd[gmps_pkg::DIR_W +: CW];
        top_dir_next = stk_rd[gmps_pkg::DIR_W-1:0];
        state_next   = gmps_pkg::ST_STEP;
      end

      gmps_pkg::ST_ORD: begin
        if (out_idx < depth_m1) begin
          stk_re = 1'b1;
        end
        state_next = gmps_pkg::ST_OWR;
      end

      gmps_pkg::ST_OWR: begin
        if (out_idx < depth_m1) begin
          load_row = stk_rd[SW-1 -: RW];
          load_col = stk_rd[gmps_pkg::DIR_W +: CW];
        end else if (out_idx != depth_m1) begin
          load_row = goal_row;
          load_col = goal_col;
          load_end = 1'b1;
        end
        if (out_free) begin
          out_load     = 1'b1;
          out_idx_next = out_idx + DW'(1);
          if (load_end) begin
            depth_next      = '0;
            load_pos_next   = '0;
            start_seen_next = 1'b0;
            state_next      = gmps_pkg::ST_CLR;
          end else begin
            state_next = gmps_pkg::ST_ORD;
          end
        end
      end

      gmps_pkg::ST_NF: begin
        load_found = 1'b0;
        load_end   = 1'b1;
        load_row   = '0;
        load_col   = '0;
        if (out_free) begin
          out_load        = 1'b1;
          depth_next      = '0;
          load_pos_next   = '0;
          start_seen_next = 1'b0;
          state_next      = gmps_pkg::ST_CLR;
        end
      end

      default: begin
        state_next = gmps_pkg::ST_CLR;
      end
    endcase
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found <= load_found;
      out_end   <= load_end;
      out_row   <= OW'((RW+OW)'(load_row));
      out_col   <= OW'((CW+OW)'(load_col));
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = gmps_pkg::TDATA_W'({out_col, out_row});
  assign m_tuser  = out_found;
  assign m_tlast  = out_end;

  // Stack never holds more cells than the grid has
  `GMPS_ASSERT_ALWAYS(a_depth_bound, depth <= CELLS, "stack depth beyond grid size")

  // While cells load, no search is in flight
  `GMPS_ASSERT_ALWAYS(a_idle_empty, state != gmps_pkg::ST_LOAD || depth == '0,
                      "stack not empty while loading")

  // A not-found result is the whole run and starts the mark clearing pass
  `GMPS_ASSERT_NEXT(a_nf_result, state == gmps_pkg::ST_NF && out_free,
                    state == gmps_pkg::ST_CLR && m_tvalid && !m_tuser && m_tlast,
                    "not-found result mishandled")

  // A push marks the new top cell
  `GMPS_ASSERT_ALWAYS(a_push_marks, !stk_we || (mark_we && mark_wdata && mark_waddr == nb_pos),
                      "pushed cell not marked")

endmodule

// ----- sv/gmps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module gmps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/gmps_nbr.sv -----
// Neighbor unit: next row/column, bounds check and linear grid address.
module gmps_nbr #(
  parameter int unsigned MAX_ROWS = 8,
  parameter int unsigned MAX_COLS = 8
) (
  input  logic [$clog2(MAX_ROWS)-1:0]          row,
  input  logic [$clog2(MAX_COLS)-1:0]          col,
  input  logic [gmps_pkg::DIR_W-1:0]           dir,
  input  logic [$clog2(MAX_ROWS+1)-1:0]        rows_use,
  input  logic [$clog2(MAX_COLS+1)-1:0]        cols_use,
  output logic                                 in_bounds,
  output logic [$clog2(MAX_ROWS)-1:0]          nrow,
  output logic [$clog2(MAX_COLS)-1:0]          ncol,
  output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0] npos
);

  localparam int unsigned RW  = $clog2(MAX_ROWS);
  localparam int unsigned CW  = $clog2(MAX_COLS);
  localparam int unsigned RCW = $clog2(MAX_ROWS+1);
  localparam int unsigned CCW = $clog2(MAX_COLS+1);
  localparam int unsigned PW  = $clog2(MAX_ROWS*MAX_COLS);

  logic [RCW:0] row_inc;
  logic [CCW:0] col_inc;

  assign row_inc = (RCW+1)'(row) + (RCW+1)'(1);
  assign col_inc = (CCW+1)'(col) + (CCW+1)'(1);

  always_comb begin
    in_bounds = 1'b0;
    nrow      = row;
    ncol      = col;
    unique case (dir)
      gmps_pkg::DIR_UP: begin
        in_bounds = (row != '0);
        nrow      = row - RW'(1);
      end
      gmps_pkg::DIR_DOWN: begin
        in_bounds = (row_inc < (RCW+1)'(rows_use));
        nrow      = RW'(row_inc);
      end
      gmps_pkg::DIR_RIGHT: begin
        in_bounds = (col_inc < (CCW+1)'(cols_use));
        ncol      = CW'(col_inc);
      end
      gmps_pkg::DIR_LEFT: begin
        in_bounds = (col != '0);
        ncol      = col - CW'(1);
      end
      default: begin
        in_bounds = 1'b0;
      end
    endcase
  end

  // Row times columns in use, plus column; stays below the cell count in bounds
  assign npos = PW'(PW'(nrow) * PW'(cols_use)) + PW'(ncol);

endmodule

// ----- dv/grid_maze_path_search_tb.sv -----
// Self-checking testbench for the depth-first maze path search block.
module grid_maze_path_search_tb;
  import gmps_pkg::*;

  localparam int GRID_ROWS_MAX = 8;
  localparam int GRID_COLS_MAX = 8;
  localparam int GRID_CELLS    = GRID_ROWS_MAX * GRID_COLS_MAX;
  localparam int SETTLE_CYCLES = 20;    // quiet time before a register write
  localparam int END_CYCLES    = 40;    // quiet time after the last result
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int STALL_LIMIT   = 4000;  // cycles with no transaction at all
  localparam int RANDOM_CELLS  = 150;

  typedef struct packed {
    logic                 found;
    logic [OUT_POS_W-1:0] row;
    logic [OUT_POS_W-1:0] col;
    logic                 path_end;
  } path_cell_t;

  // Tracks the loaded grid and the register values, solves the maze on the
  // closing cell of each grid and holds the path cells still to come out.
  class path_scoreboard;
    logic [KIND_W-1:0] grid [GRID_CELLS];
    int                load_pos;
    int                start_pos;
    bit                start_seen;
    logic [CFG_DATA_W-1:0] rows_reg;
    logic [CFG_DATA_W-1:0] cols_reg;
    path_cell_t        pending_cells [$];
    int errors, cells_taken, results_checked, found_runs, miss_runs, reg_writes;

    function new();
      foreach (grid[i]) grid[i] = KIND_OPEN;
      load_pos = 0;
      start_pos = 0;
      start_seen = 0;
      rows_reg = 4'd8;
      cols_reg = 4'd8;
      errors = 0;
      cells_taken = 0;
      results_checked = 0;
      found_runs = 0;
      miss_runs = 0;
      reg_writes = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      if (idx == CFG_ROWS) rows_reg = data;
      else cols_reg = data;
    endfunction

    function void take_cell(logic [KIND_W-1:0] kind, logic last);
      int nrow, ncol, total, goal, np, depth, top, r, c, nr, nc;
      bit hit;
      int stk_pos [GRID_CELLS];
      logic [DIR_W-1:0] stk_dir [GRID_CELLS];
      bit marked [GRID_CELLS];
      path_cell_t pc;
      cells_taken++;
      // Cells past the end of the store are dropped.
      if (load_pos < GRID_CELLS) begin
        grid[load_pos] = kind;
        if (kind == KIND_START) begin
          start_pos = load_pos;
          start_seen = 1;
        end
        load_pos++;
      end
      if (!last) return;

      nrow = (rows_reg == 0) ? 1 : ((rows_reg > GRID_ROWS_MAX) ? GRID_ROWS_MAX : rows_reg);
      ncol = (cols_reg == 0) ? 1 : ((cols_reg > GRID_COLS_MAX) ? GRID_COLS_MAX : cols_reg);
      total = nrow * ncol;
      depth = 0;
      hit = 0;
      goal = 0;
      foreach (marked[i]) marked[i] = 0;

      if (start_seen && start_pos < total) begin
        marked[start_pos] = 1;
        stk_pos[0] = start_pos;
        stk_dir[0] = DIR_UP;
        depth = 1;
        while (depth > 0 && !hit) begin
          top = depth - 1;
          if (stk_dir[top] == DIR_DONE) begin
            depth--;
            continue;
          end
          r = stk_pos[top] / ncol;
          c = stk_pos[top] % ncol;
          nr = r;
          nc = c;
          case (stk_dir[top])
            DIR_UP:    nr = r - 1;
            DIR_DOWN:  nr = r + 1;
            DIR_RIGHT: nc = c + 1;
            default:   nc = c - 1;
          endcase
          stk_dir[top] = stk_dir[top] + 1'b1;
          if (nr >= 0 && nr < nrow && nc >= 0 && nc < ncol) begin
            np = nr * ncol + nc;
            if (grid[np] == KIND_GOAL) begin
              hit = 1;
              goal = np;
            end else if (grid[np] != KIND_WALL && !marked[np] && depth < GRID_CELLS) begin
              marked[np] = 1;
              stk_pos[depth] = np;
              stk_dir[depth] = DIR_UP;
              depth++;
            end
          end
        end
      end

      if (hit) begin
        found_runs++;
        for (int i = 0; i < depth; i++) begin
          pc.found = 1'b1;
          pc.row = OUT_POS_W'(stk_pos[i] / ncol);
          pc.col = OUT_POS_W'(stk_pos[i] % ncol);
          pc.path_end = 1'b0;
          pending_cells.push_back(pc);
        end
        pc.found = 1'b1;
        pc.row = OUT_POS_W'(goal / ncol);
        pc.col = OUT_POS_W'(goal % ncol);
        pc.path_end = 1'b1;
        pending_cells.push_back(pc);
      end else begin
        miss_runs++;
        pc = '{found: 1'b0, row: '0, col: '0, path_end: 1'b1};
        pending_cells.push_back(pc);
      end
      load_pos = 0;
      start_seen = 0;
    endfunction

    function void check_result(logic found, logic [OUT_POS_W-1:0] row,
                               logic [OUT_POS_W-1:0] col, logic path_end);
      path_cell_t want;
      if (pending_cells.size() == 0) begin
        $error("unexpected result: found %0d row %0d col %0d path_end %0d",
               found, row, col, path_end);
        errors++;
        return;
      end
      want = pending_cells.pop_front();
      results_checked++;
      if (found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, found);
        errors++;
      end
      if (row !== want.row) begin
        $error("cell_row: expected %0d, actual %0d", want.row, row);
        errors++;
      end
      if (col !== want.col) begin
        $error("cell_col: expected %0d, actual %0d", want.col, col);
        errors++;
      end
      if (path_end !== want.path_end) begin
        $error("path_end: expected %0d, actual %0d", want.path_end, path_end);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [TDATA_W-1:0]    s_tdata;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [TDATA_W-1:0]    m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  path_scoreboard    sb;
  logic [KIND_W-1:0] grid_q [$];          // cells of the grid being sent
  bit                written [GRID_CELLS]; // store entries loaded since reset
  bit                calm;                // no idling on either side
  bit                hold_request;        // ask the receiver for a long hold-off
  int                random_cells;
  int                grids_sent;

  grid_maze_path_search #(
    .MAX_ROWS(GRID_ROWS_MAX),
    .MAX_COLS(GRID_COLS_MAX)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Effective dimension after the block's clamping.
  function automatic int eff_dim(int v, int maxv);
    return (v == 0) ? 1 : ((v > maxv) ? maxv : v);
  endfunction

  // Offer one cell; idle at random first, and leave tvalid high on return so
  // the next call can follow in the same step without a glitch.
  task automatic send_cell(input logic [KIND_W-1:0] kind, input logic last);
    while (!calm && $urandom_range(99) < 31) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(TDATA_W-KIND_W){1'b0}}, kind};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.take_cell(kind, last);
  endtask

  // Send the whole of grid_q with tlast on its final cell.
  task automatic send_grid();
    for (int i = 0; i < grid_q.size(); i++) begin
      if (i < GRID_CELLS) written[i] = 1;
      send_cell(grid_q[i], i == grid_q.size() - 1);
    end
    grids_sent++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Drop the cell stream, drain every expected result, then let the block
  // settle so a register write lands on an idle search engine.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_dims(input int rows_val, input int cols_val);
    wait_idle();
    cfg_write(CFG_ROWS, CFG_DATA_W'(rows_val));
    cfg_write(CFG_COLS, CFG_DATA_W'(cols_val));
    cfg_valid <= 1'b0;
  endtask

  // Fill grid_q with one random grid. Most grids are well formed (one start,
  // one goal, open cells and walls); the rest are noise. Some run short
  // (only where every cell in use has been loaded before) and some run long,
  // which pushes cells past the grid or past the end of the store.
  function automatic void build_grid(int er, int ec, bit force_over);
    int total, len, roll, sp, gp, lim;
    bit covered, noise;
    total = er * ec;
    len = total;
    covered = 1;
    for (int i = 0; i < total; i++) if (!written[i]) covered = 0;
    roll = $urandom_range(7);
    if (force_over || roll == 0) len = total + $urandom_range(1, 4);
    else if (roll == 1 && covered && total > 1) len = $urandom_range(1, total - 1);
    noise = ($urandom_range(3) == 0);
    grid_q.delete();
    for (int i = 0; i < len; i++) begin
      if (noise) grid_q.push_back(KIND_W'($urandom_range(3)));
      else grid_q.push_back(($urandom_range(99) < 30) ? KIND_WALL : KIND_OPEN);
    end
    if (!noise) begin
      lim = (len < total) ? len : total;
      if (len > total && $urandom_range(1) == 1) sp = $urandom_range(total, len - 1);
      else sp = $urandom_range(lim - 1);
      grid_q[sp] = KIND_START;
      if (len > 1) begin
        do gp = $urandom_range(len - 1); while (gp == sp);
        grid_q[gp] = KIND_GOAL;
      end
      // Occasionally lose the start cell.
      if ($urandom_range(11) == 0) grid_q[sp] = KIND_OPEN;
    end
  endfunction

  // One phase: a register setting followed by a few grids under it.
  task automatic run_phase(input int rows_val, input int cols_val, input int n_grids,
                           input bit force_over);
    set_dims(rows_val, cols_val);
    for (int g = 0; g < n_grids; g++) begin
      build_grid(eff_dim(rows_val, GRID_ROWS_MAX), eff_dim(cols_val, GRID_COLS_MAX),
                 force_over && g == 0);
      random_cells += grid_q.size();
      send_grid();
    end
  endtask

  function automatic int pick_dim();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return 0;
    if (roll == 1) return $urandom_range(9, 15);
    if (roll == 2) return $urandom_range(5, 8);
    return $urandom_range(1, 4);
  endfunction

  // Receiver: check every result transaction, idle at random and serve the
  // long hold-off with its own counter.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready)
        sb.check_result(m_tuser, m_tdata[OUT_POS_W-1:0], m_tdata[2*OUT_POS_W-1:OUT_POS_W],
                        m_tlast);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 31);
      end
    end
  end

  // Watchdog: end the run when no transaction has moved for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("grid_maze_path_search_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    sb = new();
    foreach (written[i]) written[i] = 0;
    calm = 0;
    hold_request = 0;
    random_cells = 0;
    grids_sent = 0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_ROWS;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: a single cell (zero rows acts as one), start without a
    // neighbor, goal with no start loaded.
    set_dims(0, 1);
    grid_q = '{KIND_START};
    send_grid();
    grid_q = '{KIND_GOAL};
    send_grid();
    // One row: goal to the right, then goal to the left.
    set_dims(1, 2);
    grid_q = '{KIND_START, KIND_GOAL};
    send_grid();
    grid_q = '{KIND_GOAL, KIND_START};
    send_grid();
    // Two by two: walk around a wall, goal straight up, walled-in start,
    // and two start cells where the later one wins.
    set_dims(2, 2);
    grid_q = '{KIND_START, KIND_OPEN, KIND_WALL, KIND_GOAL};
    send_grid();
    grid_q = '{KIND_GOAL, KIND_WALL, KIND_START, KIND_OPEN};
    send_grid();
    grid_q = '{KIND_START, KIND_WALL, KIND_WALL, KIND_WALL};
    send_grid();
    grid_q = '{KIND_START, KIND_START, KIND_OPEN, KIND_GOAL};
    send_grid();

    // Full-size grid past the store end, registers above the maximum,
    // with no idling on either side.
    calm = 1;
    run_phase(15, 15, 1, 1);
    wait_idle();
    calm = 0;
    // Narrow extremes; hold the receiver off while cells keep coming.
    set_dims(1, 8);
    hold_request = 1;
    for (int g = 0; g < 3; g++) begin
      build_grid(1, 8, 0);
      random_cells += grid_q.size();
      send_grid();
    end
    run_phase(8, 1, 2, 0);
    while (random_cells < RANDOM_CELLS)
      run_phase(pick_dim(), pick_dim(), $urandom_range(1, 3), 0);

    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (sb.pending_cells.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_cells.size());
      sb.errors++;
    end
    $display("covered %0d grids (%0d cells, %0d register writes): %0d paths, %0d not found",
             grids_sent, sb.cells_taken, sb.reg_writes, sb.found_runs, sb.miss_runs);
    $display("checked %0d result transactions, %0d mismatches", sb.results_checked, sb.errors);
    if (sb.errors == 0)
      $display("grid_maze_path_search_tb: done, clean");
    else
      $display("grid_maze_path_search_tb: done, errors");
    $finish;
  end

endmodule
